FILE: rtl/fkphc_pkg.sv
// Shared types and constants for the five-key press/hold classifier.
package fkphc_pkg;

  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgShortIdx  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongIdx   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRepeatIdx = 2'd2;

  // Reset values of the thresholds
  localparam logic [CountW-1:0] ShortReset  = 16'd2;
  localparam logic [CountW-1:0] LongReset   = 16'd50;
  localparam logic [CountW-1:0] RepeatReset = 16'd10;

  typedef struct packed {
    logic up_level;
    logic down_level;
    logic left_level;
    logic right_level;
    logic select_level;
  } in_t;

  typedef struct packed {
    logic up_event;
    logic down_event;
    logic left_event;
    logic right_event;
    logic select_event;
    logic select_hold_event;
  } out_t;

  typedef struct packed {
    logic [CountW-1:0] short_threshold;
    logic [CountW-1:0] long_threshold;
    logic [CountW-1:0] repeat_threshold;
  } cfg_t;

endpackage

FILE: rtl/fkphc_cfg_regs.sv
// Threshold configuration registers.
module fkphc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fkphc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [fkphc_pkg::CountW-1:0]     cfg_wdata_i,
  output fkphc_pkg::cfg_t                  cfg_o
);
  import fkphc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgShortIdx:  cfg_d.short_threshold  = cfg_wdata_i;
        CfgLongIdx:   cfg_d.long_threshold   = cfg_wdata_i;
        CfgRepeatIdx: cfg_d.repeat_threshold = cfg_wdata_i;
        default:      cfg_d = cfg_q; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_threshold  <= ShortReset;
      cfg_q.long_threshold   <= LongReset;
      cfg_q.repeat_threshold <= RepeatReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/fkphc_core.sv
// Key tracking state machine: latched key, press/hold phase and tick counter.
module fkphc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  fkphc_pkg::in_t    levels_i,
  input  fkphc_pkg::cfg_t   cfg_i,
  output fkphc_pkg::out_t   events_o
);
  import fkphc_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhPress,
    PhHold
  } phase_e;

  // Keys in priority order
  typedef enum logic [2:0] {
    KeyUp,
    KeyDown,
    KeyRight,
    KeyLeft,
    KeySelect
  } key_e;

  phase_e            phase_q, phase_d;
  key_e              key_q, key_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] cnt_inc;
  logic              key_level;
  logic              press_ev, hold_ev;

  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + 1'b1;

  // Level of the latched key only
  always_comb begin
    unique case (key_q)
      KeyUp:     key_level = levels_i.up_level;
      KeyDown:   key_level = levels_i.down_level;
      KeyRight:  key_level = levels_i.right_level;
      KeyLeft:   key_level = levels_i.left_level;
      KeySelect: key_level = levels_i.select_level;
      default:   key_level = 1'b0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    press_ev = 1'b0;
    hold_ev  = 1'b0;
    unique case (phase_q)
      PhPress: begin
        if (key_level) begin
          cnt_d = cnt_inc;
          if (cnt_inc > cfg_i.long_threshold) begin
            cnt_d   = '0;
            phase_d = PhHold;
          end
        end else begin
          press_ev = (cnt_q > cfg_i.short_threshold);
          phase_d  = PhIdle;
        end
      end
      PhHold: begin
        if (key_level) begin
          cnt_d   = cnt_inc;
          hold_ev = (cnt_inc > cfg_i.repeat_threshold);
        end else begin
          hold_ev = 1'b1;
          phase_d = PhIdle;
        end
      end
      default: begin
        cnt_d   = '0;
        phase_d = PhIdle;
        priority if (levels_i.up_level) begin
          key_d = KeyUp;
        end else if (levels_i.down_level) begin
          key_d = KeyDown;
        end else if (levels_i.right_level) begin
          key_d = KeyRight;
        end else if (levels_i.left_level) begin
          key_d = KeyLeft;
        end else begin
          key_d = KeySelect;
        end
        if (|levels_i) begin
          cnt_d   = {{(CountW-1){1'b0}}, 1'b1};
          phase_d = PhPress;
        end
      end
    endcase
  end

  // Route the pulse to the key's output; select hold pulses go separately
  always_comb begin
    events_o = '0;
    unique case (key_q)
      KeyUp:     events_o.up_event          = press_ev | hold_ev;
      KeyDown:   events_o.down_event        = press_ev | hold_ev;
      KeyRight:  events_o.right_event       = press_ev | hold_ev;
      KeyLeft:   events_o.left_event        = press_ev | hold_ev;
      KeySelect: begin
        events_o.select_event      = press_ev;
        events_o.select_hold_event = hold_ev;
      end
      default:   events_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      key_q   <= KeyUp;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: rtl/five_key_press_hold_classifier_unit.sv
// Top level of the five-key press/hold classifier with auto-repeat.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one tick of
//   the five key levels per transaction. Output channel (out_valid_o /
//   out_ready_i / out_data_o) returns exactly one event word per tick, in
//   order; all-zero words are delivered too.
//   Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i) writes thresholds:
//   0 short, 1 long, 2 repeat. Index 3 is ignored. Write only while idle.
// Path: a tick goes through the input register, then the state update writes
//   its event word into the result register; out_valid_o rises with it.
// Throughput: one tick per cycle while out_ready_i is high; the state machine
//   updates as a tick leaves the input register, which can then take a new tick.
// Reset: async, active low. Pipeline empties, state goes idle with counter
//   zero, thresholds return to 2 / 50 / 10.
// Stall: a waiting result holds while out_ready_i is low; the input
//   register takes one more transaction if it is empty, and in_ready_o stays
//   low while it is full. No transaction is lost or repeated.
module five_key_press_hold_classifier_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  fkphc_pkg::in_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output fkphc_pkg::out_t               out_data_o,
  input  logic                          cfg_we_i,
  input  logic [fkphc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fkphc_pkg::CountW-1:0]  cfg_wdata_i
);
  import fkphc_pkg::*;

  cfg_t cfg;
  out_t events;

  logic in_valid_q;
  in_t  in_data_q;
  logic out_valid_q;
  out_t out_data_q;
  logic step;

  // Stage advances when a tick is held and the result register is free or being drained
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  fkphc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  fkphc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .levels_i(in_data_q),
    .cfg_i   (cfg),
    .events_o(events)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= events;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the five-key press/hold classifier unit.
module tb;
  import fkphc_pkg::*;

  // Keys in latch priority order; the value is the bit index in a key mask.
  typedef enum int unsigned {
    KEY_UP     = 0,
    KEY_DOWN   = 1,
    KEY_RIGHT  = 2,
    KEY_LEFT   = 3,
    KEY_SELECT = 4
  } key_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESSED,
    PH_HOLD
  } key_phase_e;

  localparam int unsigned NumKeys = 5;
  localparam int unsigned NumEvents = 6;
  localparam logic [CfgIdxW-1:0] CfgUnusedIdx = 2'd3;
  localparam longint CycleLimit = 2_000_000;
  localparam int DrainCycles = 8;

  // Key masks, bit positions follow key_e
  localparam logic [NumKeys-1:0] MaskNone   = 5'b00000;
  localparam logic [NumKeys-1:0] MaskUp     = 5'b00001;
  localparam logic [NumKeys-1:0] MaskDown   = 5'b00010;
  localparam logic [NumKeys-1:0] MaskRight  = 5'b00100;
  localparam logic [NumKeys-1:0] MaskLeft   = 5'b01000;
  localparam logic [NumKeys-1:0] MaskSelect = 5'b10000;
  localparam logic [NumKeys-1:0] MaskAll    = 5'b11111;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b1;
  out_t                out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CountW-1:0]   cfg_wdata_i = '0;

  five_key_press_hold_classifier_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Shadow copy of the thresholds and of the key state machine
  logic [CountW-1:0] short_thr;
  logic [CountW-1:0] long_thr;
  logic [CountW-1:0] repeat_thr;
  logic [CountW-1:0] key_count;
  key_phase_e        key_phase;
  key_e              held_key;

  out_t   pending_events[$];   // event words still owed by the DUT, oldest first
  int     mismatches = 0;
  longint cycles = 0;
  bit     gaps_on = 1'b1;      // sender may insert idle bursts
  bit     stalls_on = 1'b1;    // receiver may drop ready in bursts
  int     stall_left = 0;

  // Names by bit position of out_t (first struct field is the MSB)
  string event_name[NumEvents] = '{"select_hold_event", "select_event", "right_event",
                                   "left_event", "down_event", "up_event"};

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Event prediction
  // ---------------------------------------------------------------------------

  function automatic in_t keys_tick(logic [NumKeys-1:0] lv);
    in_t t;
    t.up_level     = lv[KEY_UP];
    t.down_level   = lv[KEY_DOWN];
    t.right_level  = lv[KEY_RIGHT];
    t.left_level   = lv[KEY_LEFT];
    t.select_level = lv[KEY_SELECT];
    return t;
  endfunction

  // Pulse for a key; select splits into a short press and a hold line.
  function automatic out_t key_pulse(key_e k, bit from_hold);
    out_t ev;
    ev = '0;
    case (k)
      KEY_UP:    ev.up_event = 1'b1;
      KEY_DOWN:  ev.down_event = 1'b1;
      KEY_RIGHT: ev.right_event = 1'b1;
      KEY_LEFT:  ev.left_event = 1'b1;
      default: begin
        if (from_hold) ev.select_hold_event = 1'b1;
        else ev.select_event = 1'b1;
      end
    endcase
    return ev;
  endfunction

  function automatic logic [CountW-1:0] count_step(logic [CountW-1:0] c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  // Advances the shadow state by one tick and returns the event word it gives.
  function automatic out_t predict_events(in_t t);
    logic [NumKeys-1:0] lv;
    out_t ev;
    bit found;
    lv = {t.select_level, t.left_level, t.right_level, t.down_level, t.up_level};
    ev = '0;
    case (key_phase)
      PH_PRESSED: begin
        if (lv[held_key]) begin
          key_count = count_step(key_count);
          if (key_count > long_thr) begin
            key_count = '0;
            key_phase = PH_HOLD;
          end
        end else begin
          if (key_count > short_thr) ev = key_pulse(held_key, 1'b0);
          key_phase = PH_IDLE;
        end
      end
      PH_HOLD: begin
        if (lv[held_key]) begin
          key_count = count_step(key_count);
          if (key_count > repeat_thr) ev = key_pulse(held_key, 1'b1);
        end else begin
          // release from hold: pulse once, counter left alone
          ev = key_pulse(held_key, 1'b1);
          key_phase = PH_IDLE;
        end
      end
      default: begin
        key_count = '0;
        found = 1'b0;
        for (int i = 0; i < NumKeys; i++) begin
          if (!found && lv[i]) begin
            found = 1'b1;
            held_key = key_e'(i);
            key_count = CountW'(1);
            key_phase = PH_PRESSED;
          end
        end
      end
    endcase
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: both channels are sampled at the rising edge. The result check
  // runs ahead of the push so a spurious result never meets its own tick.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : result_check
    out_t want;
    logic [NumEvents-1:0] want_bits;
    logic [NumEvents-1:0] got_bits;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_events.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual %b",
                 $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        want_bits = want;
        got_bits = out_data_o;
        for (int i = 0; i < NumEvents; i++) begin
          if (want_bits[i] !== got_bits[i]) begin
            $display("%0t: %s expected %b actual %b", $time, event_name[i],
                     want_bits[i], got_bits[i]);
            mismatches++;
          end
        end
      end
    end
    if (rst_ni && in_valid_i && in_ready_o) pending_events.push_back(predict_events(in_data_i));
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver back-pressure: ready drops low in bursts of random length
  always @(negedge clk_i) begin
    if (!stalls_on) begin
      stall_left = 0;
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers: every task starts and ends at a falling edge
  // ---------------------------------------------------------------------------

  // One tick transaction; valid stays up across back-to-back calls.
  task automatic send_tick(in_t t);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic hold_keys(logic [NumKeys-1:0] lv, int n);
    repeat (n) send_tick(keys_tick(lv));
  endtask

  // Stop sending and wait for every owed event word.
  task automatic drain_results;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_events.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CountW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgShortIdx:  short_thr = val;
      CfgLongIdx:   long_thr = val;
      CfgRepeatIdx: repeat_thr = val;
      default: ;    // unused index, the unit drops it
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_thresholds(logic [CountW-1:0] s, logic [CountW-1:0] l,
                                logic [CountW-1:0] r);
    drain_results();
    write_reg(CfgShortIdx, s);
    write_reg(CfgLongIdx, l);
    write_reg(CfgRepeatIdx, r);
  endtask

  function automatic logic [CountW-1:0] rand_threshold(int hi);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CountMax;
      default: return CountW'($urandom_range(0, hi));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds 2/50/10: three ticks make a press, two do not.
  task automatic test_default_thresholds;
    hold_keys(MaskNone, 1);
    hold_keys(MaskUp, 3);
    hold_keys(MaskNone, 1);
    hold_keys(MaskDown, 2);
    hold_keys(MaskNone, 1);
  endtask

  // All keys down: they latch one by one in priority order, and the keys
  // that are not latched are ignored until release.
  task automatic test_priority_and_short_press;
    set_thresholds('0, CountMax, '0);
    write_reg(CfgUnusedIdx, 16'h0001);
    hold_keys(MaskAll, 1);
    hold_keys(MaskAll & ~MaskUp, 2);
    hold_keys(MaskRight | MaskLeft | MaskSelect, 2);
    hold_keys(MaskLeft | MaskSelect, 2);
    hold_keys(MaskSelect, 2);
    hold_keys(MaskNone, 1);
  endtask

  // Hold entry, repeat pulses and release pulse; select uses its hold line.
  // Short threshold at max so a short press gives nothing.
  task automatic test_hold_and_repeat;
    set_thresholds(CountMax, 16'd1, 16'd1);
    hold_keys(MaskSelect, 4);
    hold_keys(MaskNone, 1);
    hold_keys(MaskLeft | MaskSelect, 4);
    hold_keys(MaskSelect, 1);
    hold_keys(MaskNone, 1);
    hold_keys(MaskDown, 2);
    hold_keys(MaskNone, 1);
  endtask

  // Thresholds at their top value: long at max never enters hold, repeat at
  // max never repeats, short just below max blocks the press.
  task automatic test_max_thresholds;
    set_thresholds(CountMax - 1'b1, CountMax, '0);
    hold_keys(MaskRight, 20);
    hold_keys(MaskNone, 1);
    set_thresholds('0, '0, CountMax);
    hold_keys(MaskSelect, 20);
    hold_keys(MaskNone, 1);
  endtask

  // Mostly well-formed press/hold/release sequences with noise on the
  // other keys, plus fully random ticks. Last round runs without idling.
  task automatic test_random_sequences;
    int round;
    int items;
    int len;
    int hi;
    key_e k;
    logic [NumKeys-1:0] bit_k;
    bit paused;
    paused = 1'b0;
    for (round = 0; round < 7; round++) begin
      if (round == 6) begin
        gaps_on = 1'b0;
        stalls_on = 1'b0;
      end
      set_thresholds(rand_threshold(5), rand_threshold(15), rand_threshold(8));
      items = 0;
      while (items < 75) begin
        if (round == 3 && !paused && items >= 45) begin
          // sender holds off until the unit has delivered everything
          drain_results();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) begin
          send_tick(keys_tick(NumKeys'($urandom())));
          items++;
        end else begin
          k = key_e'($urandom_range(0, NumKeys - 1));
          bit_k = MaskUp << k;
          hi = int'(long_thr) + int'(repeat_thr) + 4;
          if (hi > 40) hi = 40;
          len = $urandom_range(1, hi);
          // first tick: nothing of higher priority, so this key latches if idle
          send_tick(keys_tick((NumKeys'($urandom()) & ~(bit_k - 1'b1)) | bit_k));
          repeat (len - 1) send_tick(keys_tick(NumKeys'($urandom()) | bit_k));
          send_tick(keys_tick(NumKeys'($urandom()) & ~bit_k));
          items += len + 1;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    short_thr  = ShortReset;
    long_thr   = LongReset;
    repeat_thr = RepeatReset;
    key_count  = '0;
    key_phase  = PH_IDLE;
    held_key   = KEY_UP;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_default_thresholds();
    test_priority_and_short_press();
    test_hold_and_repeat();
    test_max_thresholds();
    test_random_sequences();

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
